>>> hdl/wch_pkg.sv
// ----------------------------------------------------------------------------
// wch_pkg
// Shared widths and codes for the Welch-Costas hop generator.
// ----------------------------------------------------------------------------
`default_nettype none
package wch_pkg;
    localparam int MOD_BITS    = 20;
    localparam int MAX_FACTORS = 8;
    localparam int FCNT_BITS   = $clog2(MAX_FACTORS + 1);
    localparam int FIDX_BITS   = $clog2(MAX_FACTORS);
    localparam int BCNT_BITS   = $clog2(MOD_BITS + 1);
    typedef logic [MOD_BITS-1:0] t_word;

    // Modular-multiply unit opcodes
    localparam logic [1:0] MM_MUL = 2'd0;  // a*b mod m
    localparam logic [1:0] MM_DIV = 2'd1;  // a / b (quotient), remainder too
endpackage
`default_nettype wire

>>> hdl/wch_serial_unit.sv
// ----------------------------------------------------------------------------
// wch_serial_unit
// Bit-serial arithmetic: a*b mod m (shift-add, MSB first) or a divmod b
// (restoring). One bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module wch_serial_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [1:0]            i_op,
    input  wire wch_pkg::t_word  i_a,
    input  wire wch_pkg::t_word  i_b,
    input  wire wch_pkg::t_word  i_m,
    output logic                 o_done,
    output wch_pkg::t_word       o_res,
    output wch_pkg::t_word       o_quo
);
    import wch_pkg::*;

    logic              r_busy;
    logic [1:0]        r_op;
    t_word             r_a, r_b, r_m, r_acc, r_quo;
    logic [BCNT_BITS-1:0] r_cnt;
    logic [MOD_BITS:0] v_dbl, v_sum, v_red;
    logic [MOD_BITS:0] v_sh, v_sub;

    always_comb begin
        // multiply step: acc = 2*acc (+b) mod m, each add reduced once
        v_dbl = {r_acc, 1'b0};
        if (v_dbl >= {1'b0, r_m}) v_dbl = v_dbl - {1'b0, r_m};
        v_sum = v_dbl + (r_a[MOD_BITS-1] ? {1'b0, r_b} : '0);
        v_red = (v_sum >= {1'b0, r_m}) ? v_sum - {1'b0, r_m} : v_sum;
        // divide step
        v_sh  = {r_acc, r_a[MOD_BITS-1]};
        v_sub = v_sh - {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_a    <= i_a;
                r_b    <= i_b;
                r_m    <= i_m;
                r_acc  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_a <= {r_a[MOD_BITS-2:0], 1'b0};
                if (r_op == MM_MUL) begin
                    r_acc <= v_red[MOD_BITS-1:0];
                end else begin
                    if (v_sh >= {1'b0, r_b}) begin
                        r_acc <= v_sub[MOD_BITS-1:0];
                        r_quo <= {r_quo[MOD_BITS-2:0], 1'b1};
                    end else begin
                        r_acc <= v_sh[MOD_BITS-1:0];
                        r_quo <= {r_quo[MOD_BITS-2:0], 1'b0};
                    end
                end
                if (r_cnt == BCNT_BITS'(MOD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_res = r_acc;
    assign o_quo = r_quo;
endmodule
`default_nettype wire

>>> hdl/welch_costas_hop_generator.sv
// ----------------------------------------------------------------------------
// welch_costas_hop_generator
// Emits the Welch-Costas hop sequence alpha^(i+1) mod p for a programmed p.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A normal hop takes one
// bit-serial modular multiply in the shared multiply/divide unit, which
// works one bit per cycle. On the first request after reset, after a write
// of prime_modulus, or with restart set, the block first factors p-1 by
// trial division and searches for the smallest primitive root by
// square-and-multiply, every step running through the same serial unit.
// Only one request is in work at a time; the result sits in an output
// register and the next request is taken no earlier than the cycle in
// which that result is accepted. Moduli below 3 report no_root.
// Configuration is to be written by the user only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
module welch_costas_hop_generator (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire wch_pkg::t_word  i_prime_modulus,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire                  i_restart,
    output logic                 o_valid,
    input  wire                  i_ready,
    output wch_pkg::t_word       o_hop_index,
    output wch_pkg::t_word       o_hop_value,
    output wch_pkg::t_word       o_root_found,
    output logic                 o_last_hop,
    output logic                 o_no_root
);
    import wch_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_INIT   = 5'd1;
    localparam logic [4:0] S_TD_CHK = 5'd2;  // d*d <= rest ?
    localparam logic [4:0] S_TD_SQW = 5'd3;
    localparam logic [4:0] S_TD_DIV = 5'd4;  // rest divmod d
    localparam logic [4:0] S_TD_DVW = 5'd5;
    localparam logic [4:0] S_TD_NXT = 5'd6;
    localparam logic [4:0] S_G_INIT = 5'd7;
    localparam logic [4:0] S_G_FAC  = 5'd8;  // e = (p-1)/q
    localparam logic [4:0] S_G_FW   = 5'd9;
    localparam logic [4:0] S_PW_BIT = 5'd10;
    localparam logic [4:0] S_PW_MW  = 5'd11;
    localparam logic [4:0] S_PW_SQ  = 5'd12;
    localparam logic [4:0] S_PW_SW  = 5'd13;
    localparam logic [4:0] S_PW_END = 5'd14;
    localparam logic [4:0] S_HOP    = 5'd15;
    localparam logic [4:0] S_HOP_W  = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    logic [4:0] r_state;
    t_word r_p, r_root, r_pow, r_cnt;
    logic  r_root_valid;
    t_word r_fac [MAX_FACTORS];
    logic [FCNT_BITS-1:0] r_fcnt;
    logic [FIDX_BITS-1:0] r_k;
    // search registers
    t_word r_rest, r_d, r_g, r_e, r_acc, r_b;
    logic  r_divided;      // d already found to divide rest
    // sequential multiply/divide unit
    logic       mu_start, mu_done;
    logic [1:0] mu_op;
    t_word      mu_a, mu_b, mu_m, mu_res, mu_quo;
    // output register
    logic  r_ovalid;
    t_word r_oidx, r_oval, r_oroot;
    logic  r_olast, r_onone;

    wch_serial_unit u_unit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mu_start), .i_op(mu_op),
        .i_a(mu_a), .i_b(mu_b), .i_m(mu_m),
        .o_done(mu_done), .o_res(mu_res), .o_quo(mu_quo)
    );

    // take a request only while idle and when the output register is free or leaving
    assign o_ready     = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_hop_index = r_oidx;
    assign o_hop_value = r_oval;
    assign o_root_found = r_oroot;
    assign o_last_hop  = r_olast;
    assign o_no_root   = r_onone;

    logic last_fac;
    assign last_fac = ({1'b0, r_k} + 1'b1) >= r_fcnt;

    // unit launch decode
    always_comb begin
        mu_start = 1'b0;
        mu_op    = MM_MUL;
        mu_a     = r_d;
        mu_b     = r_d;
        mu_m     = r_p;
        case (r_state)
            S_TD_CHK: begin
                // d*d computed exactly as a quotient check: rest / d >= d
                mu_start = 1'b1; mu_op = MM_DIV; mu_a = r_rest; mu_b = r_d;
            end
            S_TD_DIV: begin
                mu_start = 1'b1; mu_op = MM_DIV; mu_a = r_rest; mu_b = r_d;
            end
            S_G_FAC: begin
                mu_start = 1'b1; mu_op = MM_DIV; mu_a = r_p - 1'b1;
                mu_b = r_fac[r_k];
            end
            S_PW_BIT: begin
                mu_start = r_e[0]; mu_a = r_acc; mu_b = r_b;
            end
            S_PW_SQ: begin
                mu_start = 1'b1; mu_a = r_b; mu_b = r_b;
            end
            S_HOP: begin
                mu_start = 1'b1; mu_a = r_pow; mu_b = r_root;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_p          <= t_word'(3);
            r_root       <= '0;
            r_root_valid <= 1'b0;
            r_pow        <= t_word'(1);
            r_cnt        <= '0;
            r_fcnt       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_valid) begin
                r_p          <= i_prime_modulus;
                r_root_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_state <= (i_restart || !r_root_valid) ? S_INIT : S_HOP;
                    end
                end
                S_INIT: begin
                    r_fcnt <= '0; r_root <= '0; r_pow <= t_word'(1);
                    r_cnt <= '0; r_root_valid <= 1'b1;
                    r_rest <= r_p - 1'b1; r_d <= t_word'(2); r_divided <= 1'b0;
                    r_state <= (r_p < t_word'(3)) ? S_HOP : S_TD_CHK;
                end
                S_TD_CHK: r_state <= S_TD_SQW;
                S_TD_SQW: if (mu_done) begin
                    if (mu_quo >= r_d) r_state <= S_TD_DIV;
                    else begin
                        if (r_rest > t_word'(1) && r_fcnt < FCNT_BITS'(MAX_FACTORS)) begin
                            r_fac[r_fcnt[FIDX_BITS-1:0]] <= r_rest;
                            r_fcnt <= r_fcnt + 1'b1;
                        end
                        r_state <= S_G_INIT;
                    end
                end
                S_TD_DIV: r_state <= S_TD_DVW;
                S_TD_DVW: if (mu_done) begin
                    if (mu_res == '0) begin
                        if (!r_divided && r_fcnt < FCNT_BITS'(MAX_FACTORS)) begin
                            r_fac[r_fcnt[FIDX_BITS-1:0]] <= r_d;
                            r_fcnt <= r_fcnt + 1'b1;
                        end
                        r_divided <= 1'b1;
                        r_rest    <= mu_quo;
                        r_state   <= S_TD_DIV;
                    end else r_state <= S_TD_NXT;
                end
                S_TD_NXT: begin
                    r_d <= r_d + 1'b1; r_divided <= 1'b0; r_state <= S_TD_CHK;
                end
                S_G_INIT: begin
                    r_g <= t_word'(2); r_k <= '0;
                    r_state <= (r_fcnt == '0) ? S_HOP : S_G_FAC;
                    if (r_fcnt == '0) r_root <= t_word'(2);
                end
                S_G_FAC: r_state <= S_G_FW;
                S_G_FW: if (mu_done) begin
                    r_e <= mu_quo; r_acc <= t_word'(1); r_b <= r_g;
                    r_state <= S_PW_BIT;
                end
                S_PW_BIT: begin
                    if (r_e == '0) r_state <= S_PW_END;
                    else r_state <= r_e[0] ? S_PW_MW : S_PW_SQ;
                end
                S_PW_MW: if (mu_done) begin r_acc <= mu_res; r_state <= S_PW_SQ; end
                S_PW_SQ: r_state <= S_PW_SW;
                S_PW_SW: if (mu_done) begin
                    r_b <= mu_res; r_e <= r_e >> 1; r_state <= S_PW_BIT;
                end
                S_PW_END: begin
                    if (r_acc == t_word'(1)) begin
                        // g fails; next candidate
                        r_k <= '0;
                        if (r_g + 1'b1 >= r_p) r_state <= S_HOP;
                        else begin r_g <= r_g + 1'b1; r_state <= S_G_FAC; end
                    end else if (last_fac) begin
                        r_root <= r_g; r_state <= S_HOP;
                    end else begin
                        r_k <= r_k + 1'b1; r_state <= S_G_FAC;
                    end
                end
                S_HOP: begin
                    if (r_root == '0 || r_p < t_word'(3)) begin
                        r_oidx <= '0; r_oval <= '0; r_oroot <= '0;
                        r_olast <= 1'b0; r_onone <= 1'b1; r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else r_state <= S_HOP_W;
                end
                S_HOP_W: if (mu_done) begin
                    r_oidx <= r_cnt; r_oval <= mu_res; r_oroot <= r_root;
                    r_onone <= 1'b0; r_ovalid <= 1'b1;
                    if ({1'b0, r_cnt} + (MOD_BITS+1)'(2) >= {1'b0, r_p}) begin
                        r_olast <= 1'b1; r_cnt <= '0; r_pow <= t_word'(1);
                    end else begin
                        r_olast <= 1'b0; r_cnt <= r_cnt + 1'b1; r_pow <= mu_res;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for welch_costas_hop_generator.
// Drives hop requests and modulus writes over valid/ready channels, runs an
// in-bench model of the root search and hop sequence, and checks every
// result transaction field by field against the oldest expected hop.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    import wch_pkg::*;

    localparam int  MAX_CYCLES = 5_000_000;
    localparam int  DRAIN_WAIT = 60;

    typedef struct packed {
        t_word hop_index;
        t_word hop_value;
        t_word root;
        logic  last_hop;
        logic  no_root;
    } t_hop;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_valid;
    logic  o_cfg_ready;
    t_word i_prime_modulus;
    logic  i_valid;
    logic  o_ready;
    logic  i_restart;
    logic  o_valid;
    logic  i_ready;
    t_word o_hop_index;
    t_word o_hop_value;
    t_word o_root_found;
    logic  o_last_hop;
    logic  o_no_root;

    welch_costas_hop_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_prime_modulus(i_prime_modulus),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hop_index    (o_hop_index),
        .o_hop_value    (o_hop_value),
        .o_root_found   (o_root_found),
        .o_last_hop     (o_last_hop),
        .o_no_root      (o_no_root)
    );

    // 20-unit clock period
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Expected hops, oldest first
    t_hop hop_fifo[$];
    int   err_count;
    int   cycle_count;
    bit   quiet;          // no idling on either side when set

    // Model state
    longint unsigned mdl_modulus;
    longint unsigned mdl_root;
    bit              mdl_root_ok;
    longint unsigned mdl_power;
    longint unsigned mdl_hop;

    // Square-and-multiply, m >= 3
    function automatic longint unsigned exp_mod(longint unsigned b,
                                                longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        acc = 1;
        b = b % m;
        while (e > 0) begin
            if (e[0])
                acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    // Factor p-1 by trial division, then take the smallest passing g
    function automatic void search_root();
        longint unsigned primes[MAX_FACTORS];
        int              nprimes;
        longint unsigned rest;
        longint unsigned d;
        longint unsigned g;
        longint unsigned p;
        bit              pass;
        p           = mdl_modulus;
        nprimes     = 0;
        mdl_root    = 0;
        mdl_power   = 1;
        mdl_hop     = 0;
        mdl_root_ok = 1'b1;
        if (p < 3)
            return;
        rest = p - 1;
        for (d = 2; d * d <= rest; d++) begin
            if (rest % d == 0) begin
                if (nprimes < MAX_FACTORS) begin
                    primes[nprimes] = d;
                    nprimes++;
                end
                while (rest % d == 0)
                    rest = rest / d;
            end
        end
        if (rest > 1 && nprimes < MAX_FACTORS) begin
            primes[nprimes] = rest;
            nprimes++;
        end
        for (g = 2; g < p; g++) begin
            pass = 1'b1;
            for (int k = 0; k < nprimes && pass; k++)
                if (exp_mod(g, (p - 1) / primes[k], p) == 1)
                    pass = 1'b0;
            if (pass) begin
                mdl_root = g;
                return;
            end
        end
    endfunction

    // Next hop for one accepted request
    function automatic t_hop next_hop(logic restart);
        t_hop h;
        if (restart || !mdl_root_ok)
            search_root();
        h = '0;
        if (mdl_root == 0 || mdl_modulus < 3) begin
            h.no_root = 1'b1;
            return h;
        end
        mdl_power   = (mdl_power * mdl_root) % mdl_modulus;
        h.hop_index = t_word'(mdl_hop);
        h.hop_value = t_word'(mdl_power);
        h.root      = t_word'(mdl_root);
        h.last_hop  = (mdl_hop + 2 >= mdl_modulus);
        if (h.last_hop) begin
            mdl_hop   = 0;
            mdl_power = 1;
        end else begin
            mdl_hop++;
        end
        return h;
    endfunction

    task automatic report(string what, t_word got, t_word want);
        err_count++;
        $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_hop want;
        if (i_rst_n && o_valid && i_ready) begin
            if (hop_fifo.size() == 0) begin
                err_count++;
                $display("ERROR @%0t: unexpected hop transaction", $time);
            end else begin
                want = hop_fifo.pop_front();
                if (o_hop_index !== want.hop_index)
                    report("hop_index", o_hop_index, want.hop_index);
                if (o_hop_value !== want.hop_value)
                    report("hop_value", o_hop_value, want.hop_value);
                if (o_root_found !== want.root)
                    report("root_found", o_root_found, want.root);
                if (o_last_hop !== want.last_hop)
                    report("last_hop", t_word'(o_last_hop), t_word'(want.last_hop));
                if (o_no_root !== want.no_root)
                    report("no_root", t_word'(o_no_root), t_word'(want.no_root));
            end
        end
    end

    // Receiver stalls in bursts
    always @(posedge i_clk) begin
        int stall;
        if (stall > 0) begin
            stall--;
            i_ready <= (stall == 0);
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 18);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One hop request; valid stays high across back-to-back transactions
    task automatic send_request(logic restart);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (!o_ready);
        hop_fifo.push_back(next_hop(restart));
    endtask

    // Hold off until every expected hop is back
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (hop_fifo.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_modulus(t_word p);
        wait_idle();
        i_cfg_valid     <= 1'b1;
        i_prime_modulus <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mdl_modulus = p;
        mdl_root_ok = 1'b0;
    endtask

    task automatic test_reset_modulus();
        // p = 3 from reset: period 2, wraps twice
        repeat (5) send_request(1'b0);
    endtask

    task automatic test_small_modulus();
        write_modulus(t_word'(0));
        send_request(1'b0);
        write_modulus(t_word'(1));
        send_request(1'b1);
        write_modulus(t_word'(2));
        send_request(1'b0);
    endtask

    task automatic test_wrap_restart();
        write_modulus(t_word'(7));
        repeat (7) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    task automatic test_composite();
        write_modulus(t_word'(9));
        repeat (3) send_request(1'b0);
        write_modulus(t_word'(15));
        repeat (2) send_request(1'b0);
    endtask

    task automatic test_large_modulus();
        write_modulus(20'd1048573);
        send_request(1'b0);
        send_request(1'b0);
        // all-ones written but never used
        write_modulus(20'hFFFFF);
        write_modulus(t_word'(11));
        send_request(1'b0);
    endtask

    task automatic test_random_hops();
        for (int ph = 0; ph < 5; ph++) begin
            quiet = (ph == 4);
            write_modulus(t_word'($urandom_range(3, 300)));
            for (int n = 0; n < 95; n++)
                send_request($urandom_range(0, 19) == 0);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_prime_modulus = '0;
        i_valid         = 1'b0;
        i_restart       = 1'b0;
        i_ready         = 1'b0;
        err_count       = 0;
        cycle_count     = 0;
        quiet           = 1'b0;
        mdl_modulus     = 3;
        mdl_root        = 0;
        mdl_root_ok     = 1'b0;
        mdl_power       = 1;
        mdl_hop         = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_modulus();
        test_small_modulus();
        test_wrap_restart();
        test_composite();
        test_large_modulus();
        test_random_hops();

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
